/* design/cfr_pkg.sv */
// Package for the CRC-checked frame receiver: payload structs, status codes,
// register indexes and CRC-16/MODBUS constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

    // CRC-16/MODBUS, reflected
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam int unsigned COUNT_W = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [7:0] MIN_OVERHEAD = 8'd11;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEAD_BYTE        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESPONSE_VERSION = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAIL_BYTE        = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OVERHEAD_LENGTH  = 2'd3;

    localparam logic [7:0] RST_HEAD_BYTE        = 8'h7E;
    localparam logic [7:0] RST_RESPONSE_VERSION = 8'h00;
    localparam logic [7:0] RST_TAIL_BYTE        = 8'h0D;
    localparam logic [7:0] RST_OVERHEAD_LENGTH  = 8'd11;

    typedef enum logic [2:0] {
        ST_NEED_MORE    = 3'd0,
        ST_BAD_TAIL     = 3'd1,
        ST_BAD_VERSION  = 3'd2,
        ST_DEVICE_ERROR = 3'd3,
        ST_BAD_CRC      = 3'd4,
        ST_ACCEPTED     = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] head_byte;
        logic [7:0] response_version;
        logic [7:0] tail_byte;
        logic [7:0] overhead_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_first;
        logic       chunk_last;
        logic [9:0] chunk_length;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         command_id;
        logic [COUNT_W-1:0] frame_length;
        logic               both_received;
    } t_out_item;

endpackage

`default_nettype wire

/* design/cfr_crc16_step.sv */
// One-byte CRC-16/MODBUS update, combinational (eight shift/xor steps).
// Depends on cfr_pkg for the polynomial.
`timescale 1ns / 1ps
`default_nettype none

module cfr_crc16_step (
    input  wire logic [15:0] i_crc,
    input  wire logic [7:0]  i_byte,
    output logic      [15:0] o_crc
);

    logic [15:0] acc;

    always_comb begin
        acc = i_crc ^ {8'h00, i_byte};
        for (int i = 0; i < 8; i++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ cfr_pkg::CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        o_crc = acc;
    end

endmodule

`default_nettype wire

/* design/cfr_frame_core.sv */
// Frame tracking state and end-of-chunk checks for one byte per step.
// Depends on cfr_pkg and cfr_crc16_step.
`timescale 1ns / 1ps
`default_nettype none

module cfr_frame_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire cfr_pkg::t_in_item   i_item,
    input  wire cfr_pkg::t_cfg       i_cfg,
    output cfr_pkg::t_out_item       o_result
);

    localparam int unsigned CW = cfr_pkg::COUNT_W;

    logic [CW-1:0] r_bytes_held, n_bytes_held;
    logic [CW-1:0] r_expected, n_expected;
    logic          r_restarting, n_restarting;
    logic [7:0]    r_version, n_version;
    logic [7:0]    r_dev_error, n_dev_error;
    logic [7:0]    r_command, n_command;
    logic [23:0]   r_last_three, n_last_three;
    logic [15:0]   r_crc, n_crc;
    logic [7:0]    r_first_id, n_first_id;
    logic          r_first_id_valid, n_first_id_valid;
    logic          r_two_ids, n_two_ids;

    logic [7:0]    ovh;
    logic [CW-1:0] ovh_ext;
    logic [CW-1:0] need;
    logic          restart;
    logic [CW-1:0] pos;
    logic [15:0]   crc_base;
    logic [23:0]   l3_base;
    logic [15:0]   crc_stepped;
    logic [7:0]    d;
    cfr_pkg::t_status status;

    cfr_crc16_step u_crc (
        .i_crc  (crc_base),
        .i_byte (l3_base[23:16]),
        .o_crc  (crc_stepped)
    );

    always_comb begin
        d       = i_item.data_byte;
        ovh     = (i_cfg.overhead_length < cfr_pkg::MIN_OVERHEAD) ?
                  cfr_pkg::MIN_OVERHEAD : i_cfg.overhead_length;
        ovh_ext = {{(CW-8){1'b0}}, ovh};
        restart = i_item.chunk_first && (i_item.chunk_length > {2'b00, ovh}) &&
                  (d == i_cfg.head_byte) && (r_bytes_held >= r_expected);

        // chunk start: possibly restart the frame
        n_restarting = i_item.chunk_first ? restart : r_restarting;
        pos          = restart ? '0 : r_bytes_held;
        n_expected   = restart ? ovh_ext : r_expected;
        crc_base     = restart ? cfr_pkg::CRC_INIT : r_crc;
        l3_base      = restart ? 24'h000000 : r_last_three;
        n_version    = restart ? 8'h00 : r_version;
        n_dev_error  = restart ? 8'h00 : r_dev_error;
        n_command    = restart ? 8'h00 : r_command;

        // CRC lags three bytes behind so the trailer stays out of it
        n_crc        = (pos >= CW'(3)) ? crc_stepped : crc_base;
        n_last_three = {l3_base[15:0], d};

        if (pos == CW'(1)) begin
            n_version = d;
        end else if (pos == CW'(4)) begin
            n_dev_error = d;
        end else if (pos == CW'(5)) begin
            n_command = d;
        end
        if (n_restarting) begin
            if (pos == CW'(6)) begin
                n_expected = n_expected + {1'b0, d, 8'h00};
            end else if (pos == CW'(7)) begin
                n_expected   = n_expected + {{(CW-8){1'b0}}, d};
                n_restarting = 1'b0;
            end
        end
        n_bytes_held = (pos < cfr_pkg::COUNT_MAX) ? pos + CW'(1) : pos;

        // end-of-chunk checks
        need = (n_expected > ovh_ext) ? n_expected : ovh_ext;
        if (n_bytes_held < need) begin
            status = cfr_pkg::ST_NEED_MORE;
        end else if (d != i_cfg.tail_byte) begin
            status = cfr_pkg::ST_BAD_TAIL;
        end else if (n_version != i_cfg.response_version) begin
            status = cfr_pkg::ST_BAD_VERSION;
        end else if (n_dev_error != 8'h00) begin
            status = cfr_pkg::ST_DEVICE_ERROR;
        end else if (n_crc != n_last_three[23:8]) begin
            status = cfr_pkg::ST_BAD_CRC;
        end else begin
            status = cfr_pkg::ST_ACCEPTED;
        end

        n_first_id       = r_first_id;
        n_first_id_valid = r_first_id_valid;
        n_two_ids        = r_two_ids;
        if (i_item.chunk_last) begin
            n_restarting = 1'b0;
            if (status == cfr_pkg::ST_ACCEPTED) begin
                if (!r_first_id_valid) begin
                    n_first_id       = n_command;
                    n_first_id_valid = 1'b1;
                end else if (n_command != r_first_id) begin
                    n_two_ids = 1'b1;
                end
            end
        end

        o_result.status        = status;
        o_result.command_id    = n_command;
        o_result.frame_length  = n_bytes_held;
        o_result.both_received = n_two_ids;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_held     <= '0;
            r_expected       <= '0;
            r_restarting     <= 1'b0;
            r_version        <= 8'h00;
            r_dev_error      <= 8'h00;
            r_command        <= 8'h00;
            r_last_three     <= 24'h000000;
            r_crc            <= cfr_pkg::CRC_INIT;
            r_first_id       <= 8'h00;
            r_first_id_valid <= 1'b0;
            r_two_ids        <= 1'b0;
        end else if (i_step) begin
            r_bytes_held     <= n_bytes_held;
            r_expected       <= n_expected;
            r_restarting     <= n_restarting;
            r_version        <= n_version;
            r_dev_error      <= n_dev_error;
            r_command        <= n_command;
            r_last_three     <= n_last_three;
            r_crc            <= n_crc;
            r_first_id       <= n_first_id;
            r_first_id_valid <= n_first_id_valid;
            r_two_ids        <= n_two_ids;
        end
    end

endmodule

`default_nettype wire

/* design/crc_checked_frame_receiver.sv */
// Top level of the CRC-checked frame receiver: config registers, input and
// result registers around cfr_frame_core. Depends on cfr_pkg and cfr_frame_core.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one received
//   byte per request, tagged with chunk start, chunk end and chunk length.
//   Output channel (o_out_valid / i_out_ready / o_out_item) carries one
//   result request for each byte that ends a chunk: status, command id,
//   frame length and the two-ids flag. Other bytes give no result.
//   Config port: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (head byte, response version, tail byte, overhead length); the user must
//   write only while the block is idle; the block itself does not enforce it.
//   Result path: a chunk-ending byte is held in the input register, and its
//   result is loaded into the result register once the result slot is free.
//   Throughput: one byte per cycle while no chunk-ending byte waits for the
//   result slot; the next frame state and bytewise CRC update are combinational.
//   Reset (synchronous, active low) empties both registers, clears the
//   frame state, presets the CRC to all ones and loads register defaults.
//   Stall: while a result waits, bytes that end no chunk still go through;
//   a chunk-ending byte waits in the input register, and ready drops only
//   when that register is held.
`timescale 1ns / 1ps
`default_nettype none

module crc_checked_frame_receiver (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire cfr_pkg::t_in_item                  i_in_item,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output cfr_pkg::t_out_item                      o_out_item,
    input  wire logic                               i_cfg_we,
    input  wire logic [cfr_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [7:0]                         i_cfg_data
);

    cfr_pkg::t_cfg      r_cfg;
    logic               r_in_valid;
    cfr_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    cfr_pkg::t_out_item r_out_item;

    cfr_pkg::t_out_item result;
    logic               out_free;
    logic               step;

    // result slot is free if empty or being drained this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    // a held byte moves on unless it would need the busy result slot
    assign step       = r_in_valid && (!r_in_item.chunk_last || out_free);
    assign o_in_ready = !r_in_valid || step;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head_byte        <= cfr_pkg::RST_HEAD_BYTE;
            r_cfg.response_version <= cfr_pkg::RST_RESPONSE_VERSION;
            r_cfg.tail_byte        <= cfr_pkg::RST_TAIL_BYTE;
            r_cfg.overhead_length  <= cfr_pkg::RST_OVERHEAD_LENGTH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cfr_pkg::CFG_HEAD_BYTE:        r_cfg.head_byte        <= i_cfg_data;
                cfr_pkg::CFG_RESPONSE_VERSION: r_cfg.response_version <= i_cfg_data;
                cfr_pkg::CFG_TAIL_BYTE:        r_cfg.tail_byte        <= i_cfg_data;
                cfr_pkg::CFG_OVERHEAD_LENGTH:  r_cfg.overhead_length  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    cfr_frame_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_item.chunk_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_item.chunk_last) begin
            r_out_item <= result;
        end
    end

endmodule

`default_nettype wire

/* design/cfr_checker.sv */
// Port-level assertions for the CRC-checked frame receiver, bound to the
// top level. Depends on cfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfr_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                o_out_valid,
    input  wire logic                i_out_ready,
    input  wire cfr_pkg::t_out_item  o_out_item
);

    logic r_both_seen;

    // both_received is sticky once reported
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_both_seen <= 1'b0;
        end else if (o_out_valid && o_out_item.both_received) begin
            r_both_seen <= 1'b1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_checked_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != cfr_pkg::ST_NEED_MORE)
            |-> (o_out_item.frame_length >= 17'd11))
        else $error("checked frame shorter than minimum overhead");

    a_both_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_both_seen |-> o_out_item.both_received)
        else $error("both_received dropped");

endmodule

bind crc_checked_frame_receiver cfr_checker u_cfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire

/* bench/tb_crc_checked_frame_receiver.sv */
// Testbench for crc_checked_frame_receiver: builds response frames in chunks,
// predicts each chunk-end report and checks it field by field.
// Depends on cfr_pkg and the crc_checked_frame_receiver RTL.
`timescale 1ns / 1ps

module tb_crc_checked_frame_receiver;

    localparam int unsigned CW = cfr_pkg::COUNT_W;
    localparam int unsigned STALL_LIMIT = 2000;   // cycles with no request moving
    localparam int unsigned DRAIN_CYCLES = 4;     // covers the input and result registers
    localparam int unsigned IDLE_PCT = 37;
    localparam int unsigned STRETCH_BYTES = 150;  // appended bytes with no gaps

    // ways a generated frame can be spoiled
    typedef enum {
        FLAW_NONE, FLAW_TAIL, FLAW_VERSION, FLAW_DEVICE, FLAW_CRC,
        FLAW_SHORT, FLAW_EARLY_END
    } t_flaw;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    cfr_pkg::t_in_item               i_in_item = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    cfr_pkg::t_out_item              o_out_item;
    logic                            i_cfg_we = 1'b0;
    logic [cfr_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [7:0]                      i_cfg_data = '0;

    crc_checked_frame_receiver uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the config registers
    logic [7:0] cfg_head = cfr_pkg::RST_HEAD_BYTE;
    logic [7:0] cfg_version = cfr_pkg::RST_RESPONSE_VERSION;
    logic [7:0] cfg_tail = cfr_pkg::RST_TAIL_BYTE;
    logic [7:0] cfg_overhead = cfr_pkg::RST_OVERHEAD_LENGTH;

    // Predicted frame state
    logic [CW-1:0]      rx_held = '0;
    logic [CW-1:0]      rx_expected_len = '0;
    logic               rx_len_capture = 1'b0;
    logic [7:0]         rx_version = '0;
    logic [7:0]         rx_dev_err = '0;
    logic [7:0]         rx_cmd = '0;
    logic [23:0]        rx_window = '0;     // last three bytes, newest in [7:0]
    logic [15:0]        rx_crc = cfr_pkg::CRC_INIT;
    logic [7:0]         rx_first_id = '0;
    logic               rx_first_id_valid = 1'b0;
    logic               rx_two_ids = 1'b0;

    cfr_pkg::t_out_item reports_due[$];     // predicted chunk-end reports, oldest first
    bit          idle_on = 1'b1;            // random gaps on both channels
    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    int unsigned reports_checked = 0;
    int unsigned frames_passed = 0;
    int unsigned config_settings = 0;
    int unsigned stall_cycles = 0;

    function automatic logic [15:0] crc16_modbus_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ cfr_pkg::CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic logic [7:0] eff_overhead();
        return (cfg_overhead < cfr_pkg::MIN_OVERHEAD) ? cfr_pkg::MIN_OVERHEAD : cfg_overhead;
    endfunction

    // Advance the predicted state by one byte; returns 1 when the byte ends a chunk.
    function automatic bit predict_report(input cfr_pkg::t_in_item it,
                                          output cfr_pkg::t_out_item rep);
        logic [7:0]       ovh;
        logic [CW-1:0]    pos;
        logic [CW-1:0]    need;
        cfr_pkg::t_status st;
        ovh = eff_overhead();
        rep = '0;
        if (it.chunk_first) begin
            rx_len_capture = 1'b0;
            // restart only on a long enough head chunk after a complete frame
            if (it.chunk_length > {2'b00, ovh} && it.data_byte == cfg_head
                    && rx_held >= rx_expected_len) begin
                rx_held = '0;
                rx_expected_len = CW'(ovh);
                rx_len_capture = 1'b1;
                rx_crc = cfr_pkg::CRC_INIT;
                rx_window = '0;
                rx_version = '0;
                rx_dev_err = '0;
                rx_cmd = '0;
            end
        end
        pos = rx_held;
        // CRC trails the stream by three bytes
        if (pos >= CW'(3)) rx_crc = crc16_modbus_step(rx_crc, rx_window[23:16]);
        rx_window = {rx_window[15:0], it.data_byte};
        if (pos == CW'(1)) rx_version = it.data_byte;
        else if (pos == CW'(4)) rx_dev_err = it.data_byte;
        else if (pos == CW'(5)) rx_cmd = it.data_byte;
        if (rx_len_capture) begin
            if (pos == CW'(6)) begin
                rx_expected_len = rx_expected_len + CW'({it.data_byte, 8'h00});
            end else if (pos == CW'(7)) begin
                rx_expected_len = rx_expected_len + CW'(it.data_byte);
                rx_len_capture = 1'b0;
            end
        end
        if (rx_held != cfr_pkg::COUNT_MAX) rx_held = rx_held + CW'(1);
        if (!it.chunk_last) return 1'b0;
        rx_len_capture = 1'b0;

        need = (rx_expected_len > CW'(ovh)) ? rx_expected_len : CW'(ovh);
        if (rx_held < need) st = cfr_pkg::ST_NEED_MORE;
        else if (it.data_byte != cfg_tail) st = cfr_pkg::ST_BAD_TAIL;
        else if (rx_version != cfg_version) st = cfr_pkg::ST_BAD_VERSION;
        else if (rx_dev_err != 8'h00) st = cfr_pkg::ST_DEVICE_ERROR;
        else if (rx_crc != rx_window[23:8]) st = cfr_pkg::ST_BAD_CRC;
        else begin
            st = cfr_pkg::ST_ACCEPTED;
            if (!rx_first_id_valid) begin
                rx_first_id = rx_cmd;
                rx_first_id_valid = 1'b1;
            end else if (rx_cmd != rx_first_id) begin
                rx_two_ids = 1'b1;
            end
        end
        rep.status = st;
        rep.command_id = rx_cmd;
        rep.frame_length = rx_held;
        rep.both_received = rx_two_ids;
        return 1'b1;
    endfunction

    // Result side: random back-pressure, none while idling is off
    always @(posedge i_clk)
        i_out_ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);

    // Compare each accepted result request with the oldest prediction
    always @(posedge i_clk) begin
        cfr_pkg::t_out_item due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            reports_checked++;
            if (reports_due.size() == 0) begin
                $error("unexpected result request: status %0d", o_out_item.status);
                mismatches++;
            end else begin
                due = reports_due.pop_front();
                if (o_out_item.status !== due.status) begin
                    $error("status: expected %0d, got %0d", due.status, o_out_item.status);
                    mismatches++;
                end
                if (o_out_item.command_id !== due.command_id) begin
                    $error("command_id: expected %0d, got %0d",
                           due.command_id, o_out_item.command_id);
                    mismatches++;
                end
                if (o_out_item.frame_length !== due.frame_length) begin
                    $error("frame_length: expected %0d, got %0d",
                           due.frame_length, o_out_item.frame_length);
                    mismatches++;
                end
                if (o_out_item.both_received !== due.both_received) begin
                    $error("both_received: expected %0d, got %0d",
                           due.both_received, o_out_item.both_received);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: any cycle in which a request moves resets the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // One byte request; predicts its report once the block takes it.
    task automatic send_byte(logic [7:0] d, bit first, bit last, int unsigned clen);
        cfr_pkg::t_in_item  it;
        cfr_pkg::t_out_item rep;
        it.data_byte = d;
        it.chunk_first = first;
        it.chunk_last = last;
        it.chunk_length = clen[9:0];
        if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
        if (predict_report(it, rep)) begin
            reports_due = {reports_due, rep};
            if (rep.status == cfr_pkg::ST_ACCEPTED) frames_passed++;
        end
    endtask

    // Let every predicted report arrive, then cover the bytes still in flight.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(logic [7:0] head, logic [7:0] version, logic [7:0] tail,
                              logic [7:0] overhead);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= cfr_pkg::CFG_HEAD_BYTE;
        i_cfg_data <= head;
        @(posedge i_clk);
        i_cfg_index <= cfr_pkg::CFG_RESPONSE_VERSION;
        i_cfg_data <= version;
        @(posedge i_clk);
        i_cfg_index <= cfr_pkg::CFG_TAIL_BYTE;
        i_cfg_data <= tail;
        @(posedge i_clk);
        i_cfg_index <= cfr_pkg::CFG_OVERHEAD_LENGTH;
        i_cfg_data <= overhead;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_head = head;
        cfg_version = version;
        cfg_tail = tail;
        cfg_overhead = overhead;
        config_settings++;
    endtask

    // Build one response frame under the current config and send it in chunks.
    // Layout: head, version, 2 spare, device error, command, payload length (BE),
    // filler up to the overhead, payload, CRC high, CRC low, tail.
    task automatic send_frame(int unsigned payload_len, t_flaw flaw, logic [7:0] cmd);
        logic [7:0]  frame[$];
        logic [15:0] crc;
        int unsigned ovh, total, cut, chunk_left, size, hi;
        bit          first;
        ovh = eff_overhead();
        frame = {frame, cfg_head};
        frame = {frame, (flaw == FLAW_VERSION) ? cfg_version ^ 8'($urandom_range(1, 255))
                                               : cfg_version};
        frame = {frame, 8'($urandom)};
        frame = {frame, 8'($urandom)};
        frame = {frame, (flaw == FLAW_DEVICE) ? 8'($urandom_range(1, 255)) : 8'h00};
        frame = {frame, cmd};
        frame = {frame, 8'(payload_len >> 8)};
        frame = {frame, 8'(payload_len)};
        repeat (ovh - 11 + payload_len) frame = {frame, 8'($urandom)};
        crc = cfr_pkg::CRC_INIT;
        foreach (frame[k]) crc = crc16_modbus_step(crc, frame[k]);
        if (flaw == FLAW_CRC) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        frame = {frame, crc[15:8]};
        frame = {frame, crc[7:0]};
        frame = {frame, (flaw == FLAW_TAIL) ? cfg_tail ^ 8'($urandom_range(1, 255))
                                            : cfg_tail};

        total = frame.size();
        cut = (flaw == FLAW_SHORT) ? $urandom_range(1, total - 1) : total;
        chunk_left = 0;
        size = 0;
        for (int unsigned i = 0; i < cut; i++) begin
            first = (chunk_left == 0);
            if (first) begin
                if (i == 0) begin
                    // opening chunk must be longer than the overhead to restart
                    hi = (total > 512) ? 512 : total;
                    size = (total > ovh) ? $urandom_range(ovh + 1, hi) : total;
                    // early end: chunk closes before both length bytes are in
                    chunk_left = (flaw == FLAW_EARLY_END) ? $urandom_range(2, 7) : size;
                end else begin
                    size = ($urandom_range(0, 9) == 0) ? total - i : $urandom_range(1, 20);
                    if (size > total - i) size = total - i;
                    if (size > 512) size = 512;
                    chunk_left = size;
                end
            end
            send_byte(frame[i], first, chunk_left == 1 || i == cut - 1, size);
            chunk_left--;
        end
    endtask

    // Mostly frames with random content, half of them with a random flaw, some stray bytes.
    task automatic run_random_traffic(int unsigned budget);
        int unsigned start, pick, k, plen;
        t_flaw       flaw;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 88) begin
                k = $urandom_range(0, 11);
                flaw = (k < 6) ? FLAW_NONE : t_flaw'(k - 5);
                plen = ($urandom_range(0, 49) == 0) ? $urandom_range(9, 300)
                                                    : $urandom_range(0, 8);
                send_frame(plen, flaw, 8'($urandom));
            end else begin
                // stray bytes; some carry the head byte to hit restart attempts
                repeat ($urandom_range(1, 6))
                    send_byte(($urandom_range(0, 3) == 0) ? cfg_head : 8'($urandom),
                              $urandom_range(0, 1), $urandom_range(0, 1),
                              $urandom_range(1, 512));
            end
        end
    endtask

    // Stray bytes at the field extremes: long and short chunks, non-head starts,
    // head byte with a chunk too short to restart.
    task automatic test_field_extremes();
        send_byte(8'hFF, 1'b1, 1'b0, 512);
        send_byte(cfr_pkg::RST_HEAD_BYTE, 1'b1, 1'b1, 1);
        send_byte(8'h00, 1'b0, 1'b1, 511);
        send_byte(cfr_pkg::RST_HEAD_BYTE, 1'b1, 1'b1, 11);
    endtask

    // First chunk closes before both length bytes; a zero-payload frame cannot restart.
    task automatic test_early_chunk_end();
        send_frame(1, FLAW_EARLY_END, 8'h3C);
        send_frame(0, FLAW_NONE, 8'hC3);
    endtask

    // One frame per rejecting outcome and two accepted ones; their distinct ids set the both-received flag.
    task automatic test_check_outcomes();
        logic [7:0] id;
        id = 8'($urandom);
        send_frame($urandom_range(1, 6), FLAW_NONE, id);
        send_frame($urandom_range(1, 6), FLAW_NONE, id ^ 8'h80);
        send_frame($urandom_range(1, 6), FLAW_TAIL, 8'($urandom));
        send_frame($urandom_range(1, 6), FLAW_VERSION, 8'($urandom));
        send_frame($urandom_range(1, 6), FLAW_DEVICE, 8'($urandom));
        send_frame($urandom_range(1, 6), FLAW_CRC, 8'($urandom));
        send_frame($urandom_range(1, 6), FLAW_SHORT, 8'($urandom));
    endtask

    // Random traffic under several register settings, extremes included.
    // Overhead 0 and 5 fall back to the minimum of 11.
    task automatic test_config_sweep();
        set_config(8'h00, 8'hFF, 8'hFF, 8'h00);
        run_random_traffic(100);
        set_config(8'hFF, 8'h5A, 8'h00, 8'h05);
        run_random_traffic(100);
        set_config(8'hA5, 8'h33, 8'hC3, 8'hFF);
        run_random_traffic(250);
        set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(11, 40)));
        run_random_traffic(100);
        set_config(cfr_pkg::RST_HEAD_BYTE, cfr_pkg::RST_RESPONSE_VERSION,
                   cfr_pkg::RST_TAIL_BYTE, cfr_pkg::RST_OVERHEAD_LENGTH);
        run_random_traffic(100);
    endtask

    // Long stretch with no gaps on either side: a frame, a run of bytes
    // appended to it, then a fresh frame and some traffic.
    task automatic test_gap_free_stretch();
        wait_idle();
        idle_on = 1'b0;
        send_frame(2, FLAW_NONE, 8'($urandom));
        for (int unsigned n = 0; n < STRETCH_BYTES; n++)
            send_byte(8'($urandom), 1'b0, (n % 16) == 15 || n == STRETCH_BYTES - 1,
                      $urandom_range(1, 512));
        send_frame(3, FLAW_NONE, 8'($urandom));
        run_random_traffic(40);
        wait_idle();
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_early_chunk_end();
        test_check_outcomes();
        test_config_sweep();
        test_gap_free_stretch();

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d bytes, checked %0d result requests, %0d frames accepted.",
                 bytes_sent, reports_checked, frames_passed);
        $display("%0d register settings applied, plus one stretch with no idle cycles.",
                 config_settings);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
design/cfr_pkg.sv
design/cfr_crc16_step.sv
design/cfr_frame_core.sv
design/crc_checked_frame_receiver.sv
design/cfr_checker.sv
bench/tb_crc_checked_frame_receiver.sv
